### rtl/char_lcd_bus_write_sequencer_top_defines.svh
// ---------------------------------------------------------------------------
// char_lcd_bus_write_sequencer_top_defines
// assertion macros shared by the lcd bus write sequencer
// ---------------------------------------------------------------------------
`ifndef CHAR_LCD_BUS_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define CHAR_LCD_BUS_WRITE_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CLBWS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CLBWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/clbws_pkg.sv
// ---------------------------------------------------------------------------
// clbws_pkg
// shared types, codes and the init sequence table of the lcd bus sequencer
// ---------------------------------------------------------------------------
package clbws_pkg;

  // input kind codes
  localparam logic [1:0] KIND_CMD  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_INIT = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FOUR_BIT  = 2'd0;
  localparam logic [1:0] REG_PULSE_MS  = 2'd1;
  localparam logic [1:0] REG_POWER_UP  = 2'd2;

  // reset values of the registers
  localparam logic [7:0] RESET_PULSE_MS    = 8'd2;
  localparam logic [7:0] RESET_POWER_UP_MS = 8'd40;

  // lcd commands and nibbles used during init
  localparam logic [7:0] CMD_FUNCTION_SET_8 = 8'h38;
  localparam logic [7:0] CMD_DISPLAY_ON     = 8'h0C;
  localparam logic [7:0] CMD_CLEAR          = 8'h01;
  localparam logic [3:0] NIB_FUNC_HI        = 4'h2;
  localparam logic [3:0] NIB_FUNC_LO        = 4'h8;

  // phase counter covers the longest sequence (15 phases)
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] LAST_WRITE_8 = 4'd1;
  localparam logic [STEP_W-1:0] LAST_WRITE_4 = 4'd3;
  localparam logic [STEP_W-1:0] LAST_INIT_8  = 4'd6;
  localparam logic [STEP_W-1:0] LAST_INIT_4  = 4'd14;

  // default depth of the job queue between front and back
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  // one classified job
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] data_byte;
  } job_t;

  // live configuration
  typedef struct packed {
    logic       four_bit_mode;
    logic [7:0] enable_pulse_ms;
    logic [7:0] power_up_wait_ms;
  } cfg_t;

  // bus value of strobe k of the init sequence (after the wait phase)
  function automatic logic [7:0] init_bus(input logic four, input logic [2:0] k);
    logic [7:0] bus;
    bus = 8'h00;
    if (four) begin
      unique case (k)
        3'd0:    bus = {4'h0, NIB_FUNC_HI};
        3'd1:    bus = {4'h0, NIB_FUNC_HI};
        3'd2:    bus = {4'h0, NIB_FUNC_LO};
        3'd3:    bus = {4'h0, CMD_DISPLAY_ON[7:4]};
        3'd4:    bus = {4'h0, CMD_DISPLAY_ON[3:0]};
        3'd5:    bus = {4'h0, CMD_CLEAR[7:4]};
        3'd6:    bus = {4'h0, CMD_CLEAR[3:0]};
        default: bus = 8'h00;
      endcase
    end else begin
      unique case (k)
        3'd0:    bus = CMD_FUNCTION_SET_8;
        3'd1:    bus = CMD_DISPLAY_ON;
        3'd2:    bus = CMD_CLEAR;
        default: bus = 8'h00;
      endcase
    end
    return bus;
  endfunction

endpackage

### rtl/clbws_front.sv
// ---------------------------------------------------------------------------
// clbws_front
// accepts input items, classifies them into jobs, drops unused kinds
// ---------------------------------------------------------------------------
module clbws_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        kind,
  input  logic [7:0]        value,
  output logic              job_push,
  output clbws_pkg::job_t   job,
  input  logic              job_ready
);
  import clbws_pkg::*;

  logic job_valid;
  logic job_valid_next;
  logic accept;
  logic keep;
  job_t job_reg;
  job_t job_class;

  // stage takes an item when empty or when its job moves on
  assign full   = job_valid && !job_ready;
  assign accept = push && !full;

  // classify the item
  always_comb begin
    job_class.is_init   = (kind == KIND_INIT);
    job_class.rs        = (kind == KIND_DATA);
    job_class.data_byte = value;
    keep = (kind == KIND_CMD) || (kind == KIND_DATA) || (kind == KIND_INIT);
  end

  always_comb begin
    if (accept) begin
      job_valid_next = keep;
    end else begin
      job_valid_next = job_valid && !job_ready;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= job_valid_next;
    end
  end

  // job payload
  always_ff @(posedge clk) begin
    if (accept) begin
      job_reg <= job_class;
    end
  end

  assign job_push = job_valid;
  assign job      = job_reg;

endmodule

### rtl/clbws_queue.sv
// ---------------------------------------------------------------------------
// clbws_queue
// short job queue between the front and the phase emitter
// ---------------------------------------------------------------------------
module clbws_queue #(
  parameter int QUEUE_DEPTH = clbws_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  clbws_pkg::job_t   wr_job,
  output logic              rd_valid,
  input  logic              rd_pop,
  output clbws_pkg::job_t   rd_job
);
  import clbws_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_job   = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (!do_wr && do_rd) begin
        count <= count - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

endmodule

### rtl/clbws_back.sv
// ---------------------------------------------------------------------------
// clbws_back
// phase emitter: expands one job into bus phases into an output register
// ---------------------------------------------------------------------------
module clbws_back (
  input  logic              clk,
  input  logic              rst,
  input  clbws_pkg::cfg_t   cfg,
  input  logic              job_valid,
  input  clbws_pkg::job_t   job_in,
  output logic              job_pop,
  output logic              empty,
  input  logic              pop,
  output logic              register_select,
  output logic [7:0]        bus_lines,
  output logic              enable_level,
  output logic [7:0]        hold_ms,
  output logic              last
);
  import clbws_pkg::*;

  logic              active;
  logic [STEP_W-1:0] step;
  job_t              cur;
  logic              out_valid;
  logic              out_take;
  logic              emit;
  logic              load;
  logic [STEP_W-1:0] s;
  logic              ph_rs;
  logic [7:0]        ph_bus;
  logic              ph_en;
  logic [7:0]        ph_hold;
  logic              ph_last;

  // phase of the current job at the current step
  always_comb begin
    s       = step - 1'b1;
    ph_rs   = cur.rs;
    ph_bus  = cur.data_byte;
    ph_en   = 1'b0;
    ph_hold = 8'h00;
    ph_last = 1'b0;
    if (cur.is_init) begin
      if (step == '0) begin
        // power-up wait
        ph_bus  = 8'h00;
        ph_hold = cfg.power_up_wait_ms;
      end else begin
        ph_bus  = init_bus(cfg.four_bit_mode, s[3:1]);
        ph_en   = !s[0];
        ph_hold = ph_en ? cfg.enable_pulse_ms : 8'h00;
      end
      ph_last = cfg.four_bit_mode ? (step == LAST_INIT_4) : (step == LAST_INIT_8);
    end else begin
      ph_en   = !step[0];
      ph_hold = ph_en ? cfg.enable_pulse_ms : 8'h00;
      if (cfg.four_bit_mode) begin
        ph_bus  = step[1] ? {4'h0, cur.data_byte[3:0]} : {4'h0, cur.data_byte[7:4]};
        ph_last = (step == LAST_WRITE_4);
      end else begin
        ph_last = (step == LAST_WRITE_8);
      end
    end
  end

  // handshake between sequencer, queue and output register
  assign out_take = !out_valid || pop;
  assign emit     = active && out_take;
  assign load     = job_valid && (!active || (emit && ph_last));
  assign job_pop  = load;

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
        step   <= '0;
      end else if (emit) begin
        active <= !ph_last;
        step   <= step + 1'b1;
      end
      if (out_take) begin
        out_valid <= emit;
      end
    end
  end

  // job and result payload
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= job_in;
    end
    if (emit) begin
      register_select <= ph_rs;
      bus_lines       <= ph_bus;
      enable_level    <= ph_en;
      hold_ms         <= ph_hold;
      last            <= ph_last;
    end
  end

  assign empty = !out_valid;

endmodule

### rtl/char_lcd_bus_write_sequencer_top.sv
// ---------------------------------------------------------------------------
// char_lcd_bus_write_sequencer_top
// character-lcd parallel bus write sequencer, read/write line held low
//
// Items enter on a queue-like port: push with kind and value, accepted
// when push is high and full is low. Kind 0 writes a command, kind 1
// writes data, kind 2 runs the init sequence, kind 3 is dropped.
// Bus phases leave on a queue-like port: a phase is shown while empty is
// low and taken when pop is high. last marks the final phase of an item.
// A write gives 2 phases (eight-bit) or 4 phases (four-bit); init gives
// 7 or 15 phases. The phase emitter produces one phase per cycle while
// phases are taken. An item passes the front, queue and emitter job
// registers before its first phase shows. A small job queue sits between
// the classifier and the phase emitter, so items keep coming in while the
// result side is stalled; when pop is held low the current phase waits
// and full rises once the queue fills. Reset empties both sides and loads
// the register defaults: eight-bit bus, 2 ms enable pulse, 40 ms power-up
// wait. The user must write the registers via cfg_valid/cfg_ready (always
// ready) only while the block is idle; the block does not enforce it.
// ---------------------------------------------------------------------------
`include "char_lcd_bus_write_sequencer_top_defines.svh"

module char_lcd_bus_write_sequencer_top #(
  parameter int QUEUE_DEPTH = clbws_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] kind,
  input  logic [7:0] value,
  output logic       empty,
  input  logic       pop,
  output logic       register_select,
  output logic [7:0] bus_lines,
  output logic       enable_level,
  output logic [7:0] hold_ms,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import clbws_pkg::*;

  cfg_t cfg;
  logic job_push;
  logic job_ready;
  job_t job_front;
  logic q_valid;
  logic q_pop;
  job_t q_job;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.four_bit_mode    <= 1'b0;
      cfg.enable_pulse_ms  <= RESET_PULSE_MS;
      cfg.power_up_wait_ms <= RESET_POWER_UP_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOUR_BIT: cfg.four_bit_mode    <= cfg_data[0];
        REG_PULSE_MS: cfg.enable_pulse_ms  <= cfg_data;
        REG_POWER_UP: cfg.power_up_wait_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // classifier
  clbws_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .value     (value),
    .job_push  (job_push),
    .job       (job_front),
    .job_ready (job_ready)
  );

  // job queue
  clbws_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (job_push),
    .wr_ready (job_ready),
    .wr_job   (job_front),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_job   (q_job)
  );

  // phase emitter
  clbws_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .job_valid       (q_valid),
    .job_in          (q_job),
    .job_pop         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .register_select (register_select),
    .bus_lines       (bus_lines),
    .enable_level    (enable_level),
    .hold_ms         (hold_ms),
    .last            (last)
  );

  // checks
  `CLBWS_ASSERT_NEXT(a_job_held, clk, rst, job_push && !job_ready, job_push && $stable(job_front), "job changed while queue full")
  `CLBWS_ASSERT_IMPL(a_strobe_not_last, clk, rst, !empty && enable_level, !last, "item ended with enable high")
  `CLBWS_ASSERT_IMPL(a_pulse_hold, clk, rst, !empty && enable_level, hold_ms == cfg.enable_pulse_ms, "enable-high phase with wrong hold")
  `CLBWS_ASSERT_IMPL(a_wait_phase, clk, rst, !empty && !enable_level && hold_ms != 8'h00, bus_lines == 8'h00 && !register_select, "bad power-up wait phase")

endmodule
